// ----- design/tir_pkg.sv -----
// ----------------------------------------------------------------------------
// tir_pkg: shared constants of the table interpolation reader
// field widths, mode codes and default sizes used by the reader and its checker
// ----------------------------------------------------------------------------
package tir_pkg;

   // default sizes
   localparam int TIR_TABLE_DEPTH   = 1024;
   localparam int TIR_FRACTION_BITS = 16;

   // field widths
   localparam int SAMPLE_W   = 24;
   localparam int PHASE_W    = 26;
   localparam int WIDX_W     = 10;
   localparam int LEN_W      = 11;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 64;

   // item modes
   localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HERMITE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

   // sample range
   localparam int SAMPLE_MAX = 8388607;
   localparam int SAMPLE_MIN = -8388608;

endpackage

// ----- design/table_interpolation_reader_unit.sv -----
// ----------------------------------------------------------------------------
// table_interpolation_reader_unit: sample table with linear and hermite readout
// ----------------------------------------------------------------------------
// The req channel carries one word per item. req_tuser is the mode: write one
// table entry, linear read or hermite read at a fractional phase. Only reads
// produce a word on the rsp channel, one interpolated Q1.23 sample each.
// csr_write_enable loads the table length; write it only while idle.
// The table sits in four interleaved banks so the four neighbours of a read
// come out together; a new word can be taken every cycle unless rsp back-pressure holds the pipeline.
// From req acceptance to rsp_tvalid a read passes the bank read register,
// loaded at the accepting edge, then one coefficient stage, three multiply /
// round-and-add pairs of the Horner chain and the final round and saturate
// register.
// Reset clears the pipeline valid bits and the table length; table contents
// are not cleared and must be written before they are read.
// When rsp_tready is low with a result waiting, the whole pipeline holds and
// req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module table_interpolation_reader_unit #(
   parameter int TABLE_DEPTH   = tir_pkg::TIR_TABLE_DEPTH,
   parameter int FRACTION_BITS = tir_pkg::TIR_FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // table length
   input  logic                              csr_write_enable,
   input  logic [tir_pkg::LEN_W-1:0]         csr_write_data,
   // request words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // phase[25:0], write_index[35:26], write_sample[59:36], zero pad
   input  logic [tir_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[1:0]
   input  logic [tir_pkg::MODE_W-1:0]        req_tuser,
   // result words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // value[23:0]
   output logic [tir_pkg::SAMPLE_W-1:0]      rsp_tdata
);
   import tir_pkg::*;

   localparam int F     = FRACTION_BITS;
   localparam int IPW   = PHASE_W - F;
   localparam int LENW  = $clog2(TABLE_DEPTH + 1);
   localparam int BD    = (TABLE_DEPTH + 3) / 4;
   localparam int RW    = (BD > 1) ? $clog2(BD) : 1;
   localparam int KW    = 28;
   localparam int AW    = 32;
   localparam int PW    = AW + F + 1;
   localparam int LW    = SAMPLE_W + F + 2;
   localparam int LSW   = LW + 1;

   localparam logic signed [PW-1:0]  HALF_P = PW'(1) << (F - 1);
   localparam logic signed [LSW-1:0] HALF_L = LSW'(1) << (F - 1);
   localparam logic [F:0]            ONE_F  = (F + 1)'(1) << F;
   localparam logic signed [AW-1:0]  SMAX_A = AW'(SAMPLE_MAX);
   localparam logic signed [AW-1:0]  SMIN_A = AW'(SAMPLE_MIN);
   localparam logic signed [LSW-1:0] SMAX_L = LSW'(SAMPLE_MAX);
   localparam logic signed [LSW-1:0] SMIN_L = LSW'(SAMPLE_MIN);

   // request fields
   logic [PHASE_W-1:0]         phase;
   logic [WIDX_W-1:0]          widx;
   logic [SAMPLE_W-1:0]        wsample;
   logic                       accept;
   logic                       adv;

   // pipeline valid bits
   logic                       v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;

   assign phase   = req_tdata[PHASE_W-1:0];
   assign widx    = req_tdata[PHASE_W +: WIDX_W];
   assign wsample = req_tdata[PHASE_W+WIDX_W +: SAMPLE_W];

   // whole pipeline moves when the output slot is free or being taken
   assign adv        = !v9_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && req_tready;

   // table length register, clipped to the depth
   logic [LENW-1:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_write_enable) begin
         len_ff <= (int'(csr_write_data) > TABLE_DEPTH) ? LENW'(TABLE_DEPTH)
                                                        : LENW'(csr_write_data);
      end
   end

   // stage 0: neighbour indexes, masks and bank rows
   logic [IPW-1:0]  i1;
   logic [F-1:0]    f0;
   logic [3:0]      msk_in;
   logic            lz_in;
   logic [1:0]      rot_in;
   logic [RW-1:0]   row_in [4];
   logic            rd_item;

   assign rd_item = accept && (req_tuser == MODE_LINEAR || req_tuser == MODE_HERMITE);

   always_comb begin
      int nidx;
      int row;
      logic [1:0] kb;
      if (len_ff == LENW'(1)) begin
         i1 = '0;
         f0 = '0;
      end else begin
         i1 = phase[PHASE_W-1:F];
         f0 = phase[F-1:0];
      end
      for (int k = 0; k < 4; k++) begin
         nidx      = int'(i1) - 1 + k;
         msk_in[k] = (nidx >= 0) && (nidx < int'(len_ff));
      end
      lz_in  = (len_ff != LENW'(1)) && (int'(i1) >= int'(len_ff) - 1);
      rot_in = i1[1:0] - 2'd1;
      for (int b = 0; b < 4; b++) begin
         kb   = 2'(b) - rot_in;
         nidx = int'(i1) - 1 + int'(kb);
         row  = nidx >>> 2;
         row_in[b] = (nidx < 0 || row >= BD) ? '0 : RW'(row);
      end
   end

   // four interleaved banks, one write and one registered read each
   logic [SAMPLE_W-1:0] rd_data [4];
   logic                wr_en;

   assign wr_en = accept && req_tuser == MODE_WRITE && int'(widx) < TABLE_DEPTH;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [SAMPLE_W-1:0] bank_mem [BD];
      logic [SAMPLE_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en && widx[1:0] == 2'(b)) begin
            bank_mem[RW'(widx >> 2)] <= wsample;
         end
         if (adv) begin
            rd_ff <= bank_mem[row_in[b]];
         end
      end

      assign rd_data[b] = rd_ff;
   end

   // pipeline registers
   logic [F-1:0]               f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff;
   logic [1:0]                 rot1_ff;
   logic [3:0]                 msk1_ff;
   logic                       lz1_ff, lz2_ff, lz3_ff, lz4_ff, lz5_ff, lz6_ff, lz7_ff, lz8_ff;
   logic                       hm1_ff, hm2_ff, hm3_ff, hm4_ff, hm5_ff, hm6_ff, hm7_ff, hm8_ff;
   logic signed [SAMPLE_W-1:0] ya2_ff, yb2_ff;
   logic signed [KW-1:0]       k0_2_ff, k1_2_ff, k2_2_ff, k3_2_ff;
   logic signed [KW-1:0]       k0_3_ff, k1_3_ff, k2_3_ff;
   logic signed [KW-1:0]       k0_4_ff, k1_4_ff, k0_5_ff, k1_5_ff, k0_6_ff, k0_7_ff;
   logic signed [PW-1:0]       p3_ff, p5_ff, p7_ff;
   logic signed [LW-1:0]       la3_ff, lb3_ff;
   logic signed [LSW-1:0]      ls4_ff, ls5_ff, ls6_ff, ls7_ff, ls8_ff;
   logic signed [AW-1:0]       a4_ff, a6_ff, a8_ff;
   logic [SAMPLE_W-1:0]        out_ff;

   // stage 2: rotate banks into neighbour order and form coefficients
   logic signed [SAMPLE_W-1:0] y_in [4];
   logic signed [KW-1:0]       e0, e1, e2, e3;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         y_in[k] = msk1_ff[k] ? $signed(rd_data[2'(rot1_ff + 2'(k))]) : '0;
      end
      e0 = KW'(y_in[0]);
      e1 = KW'(y_in[1]);
      e2 = KW'(y_in[2]);
      e3 = KW'(y_in[3]);
   end

   // stage 3 weights
   logic [F:0] wa_in;
   assign wa_in = ONE_F - {1'b0, f2_ff};

   // stage 9: round, saturate and select
   logic signed [AW-1:0]  h_in;
   logic signed [LSW-1:0] l_in;
   logic [SAMPLE_W-1:0]   out_in;

   always_comb begin
      h_in = (a8_ff + AW'(1)) >>> 1;
      l_in = (ls8_ff + HALF_L) >>> F;
      if (hm8_ff) begin
         if (h_in > SMAX_A)      out_in = SAMPLE_W'(SMAX_A);
         else if (h_in < SMIN_A) out_in = SAMPLE_W'(SMIN_A);
         else                    out_in = SAMPLE_W'(h_in);
      end else if (lz8_ff) begin
         out_in = '0;
      end else begin
         if (l_in > SMAX_L)      out_in = SAMPLE_W'(SMAX_L);
         else if (l_in < SMIN_L) out_in = SAMPLE_W'(SMIN_L);
         else                    out_in = SAMPLE_W'(l_in);
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff} <= '0;
      end else if (adv) begin
         v1_ff <= rd_item;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1
         f1_ff   <= f0;
         rot1_ff <= rot_in;
         msk1_ff <= msk_in;
         lz1_ff  <= lz_in;
         hm1_ff  <= (req_tuser == MODE_HERMITE);
         // stage 2
         f2_ff   <= f1_ff;
         lz2_ff  <= lz1_ff;
         hm2_ff  <= hm1_ff;
         ya2_ff  <= y_in[1];
         yb2_ff  <= y_in[2];
         k0_2_ff <= e1 <<< 1;
         k1_2_ff <= e2 - e0;
         k3_2_ff <= ((e1 - e2) <<< 1) + (e1 - e2) + (e3 - e0);
         k2_2_ff <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
         // stage 3: first horner product and linear products
         p3_ff   <= k3_2_ff * $signed({1'b0, f2_ff});
         la3_ff  <= ya2_ff * $signed({1'b0, wa_in});
         lb3_ff  <= yb2_ff * $signed({1'b0, f2_ff});
         f3_ff   <= f2_ff;
         k0_3_ff <= k0_2_ff;
         k1_3_ff <= k1_2_ff;
         k2_3_ff <= k2_2_ff;
         lz3_ff  <= lz2_ff;
         hm3_ff  <= hm2_ff;
         // stage 4
         a4_ff   <= AW'((p3_ff + HALF_P) >>> F) + AW'(k2_3_ff);
         ls4_ff  <= LSW'(la3_ff) + LSW'(lb3_ff);
         f4_ff   <= f3_ff;
         k0_4_ff <= k0_3_ff;
         k1_4_ff <= k1_3_ff;
         lz4_ff  <= lz3_ff;
         hm4_ff  <= hm3_ff;
         // stage 5
         p5_ff   <= a4_ff * $signed({1'b0, f4_ff});
         ls5_ff  <= ls4_ff;
         f5_ff   <= f4_ff;
         k0_5_ff <= k0_4_ff;
         k1_5_ff <= k1_4_ff;
         lz5_ff  <= lz4_ff;
         hm5_ff  <= hm4_ff;
         // stage 6
         a6_ff   <= AW'((p5_ff + HALF_P) >>> F) + AW'(k1_5_ff);
         ls6_ff  <= ls5_ff;
         f6_ff   <= f5_ff;
         k0_6_ff <= k0_5_ff;
         lz6_ff  <= lz5_ff;
         hm6_ff  <= hm5_ff;
         // stage 7
         p7_ff   <= a6_ff * $signed({1'b0, f6_ff});
         ls7_ff  <= ls6_ff;
         k0_7_ff <= k0_6_ff;
         lz7_ff  <= lz6_ff;
         hm7_ff  <= hm6_ff;
         // stage 8
         a8_ff   <= AW'((p7_ff + HALF_P) >>> F) + AW'(k0_7_ff);
         ls8_ff  <= ls7_ff;
         lz8_ff  <= lz7_ff;
         hm8_ff  <= hm7_ff;
         // stage 9
         out_ff  <= out_in;
      end
   end

   assign rsp_tvalid = v9_ff;
   assign rsp_tdata  = out_ff;

endmodule

// ----- design/tir_port_check.sv -----
// ----------------------------------------------------------------------------
// tir_port_check: port-level checks of the table interpolation reader
// watches reset, stall and back-pressure behavior on the channels
// ----------------------------------------------------------------------------
module tir_port_check (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [tir_pkg::SAMPLE_W-1:0] rsp_tdata
);
   import tir_pkg::*;

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

   // free output slot means the input side is open
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("req_tready low with free output");

   // input closes only under output back-pressure
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without stall");

endmodule

bind table_interpolation_reader_unit tir_port_check u_tir_port_check (.*);

// ----- tb/table_interpolation_reader_unit_tb.sv -----
// ----------------------------------------------------------------------------
// table_interpolation_reader_unit_tb: self-checking bench for the table reader
// fills the low region and the last entries of the sample table, then checks
// linear and hermite reads against an in-bench interpolation predictor over
// several table lengths, with random idle bursts on the request side and
// stall bursts on the result side
// ----------------------------------------------------------------------------
module table_interpolation_reader_unit_tb;
   import tir_pkg::*;

   localparam int DEPTH = TIR_TABLE_DEPTH;
   localparam int FB    = TIR_FRACTION_BITS;
   localparam int DRAIN = 40;
   localparam int FILL  = 160;

   // one directed row: optional typed-in expectation
   typedef struct {
      logic [MODE_W-1:0]   mode;
      logic [PHASE_W-1:0]  phase;
      logic [WIDX_W-1:0]   widx;
      logic [SAMPLE_W-1:0] sample;
      bit                  has_fixed;
      logic [SAMPLE_W-1:0] fixed_value;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [LEN_W-1:0] csr_write_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;

   // predictor state
   logic signed [SAMPLE_W-1:0] sample_mem [DEPTH];
   int unsigned                length_reg;

   logic [SAMPLE_W-1:0] expected_values [$];
   int  error_count = 0;
   int  read_count = 0;
   int  write_count = 0;
   bit  stall_enable = 1'b1;
   int  stall_left = 0;

   table_interpolation_reader_unit dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // floor((x + 2^(sh-1)) / 2^sh) via arithmetic shift
   function automatic longint round_shift(input longint x, input int sh);
      return (x + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp_sample(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   function automatic longint entry_at(input longint idx, input longint len);
      if (idx < 0 || idx >= len) return 0;
      return sample_mem[idx];
   endfunction

   // interpolated value for one read
   function automatic logic [SAMPLE_W-1:0] interpolate(input logic [MODE_W-1:0] mode,
                                                     input logic [PHASE_W-1:0] phase);
      longint len, ip, f, a, b, y0, y1, y2, y3, k0, k1, k2, k3, acc, v;
      len = (length_reg > DEPTH) ? DEPTH : length_reg;
      ip  = phase >> FB;
      f   = phase & ((1 << FB) - 1);
      if (len == 1) v = sample_mem[0];
      else if (len == 0) v = 0;
      else if (mode == MODE_LINEAR) begin
         if (ip >= len - 1) v = 0;
         else begin
            a = sample_mem[ip];
            b = sample_mem[ip + 1];
            v = round_shift(a * ((longint'(1) << FB) - f) + b * f, FB);
         end
      end else begin
         y0 = entry_at(ip - 1, len);
         y1 = entry_at(ip, len);
         y2 = entry_at(ip + 1, len);
         y3 = entry_at(ip + 2, len);
         k0 = 2 * y1;
         k1 = y2 - y0;
         k3 = 3 * (y1 - y2) + (y3 - y0);
         k2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
         acc = round_shift(k3 * f, FB) + k2;
         acc = round_shift(acc * f, FB) + k1;
         acc = round_shift(acc * f, FB) + k0;
         v = round_shift(acc, 1);
      end
      return SAMPLE_W'(clamp_sample(v));
   endfunction

   // drive one word and wait for acceptance, with an optional idle burst first
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [PHASE_W-1:0] phase,
                            input logic [WIDX_W-1:0] widx, input logic [SAMPLE_W-1:0] sample,
                            input bit gaps);
      int n;
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 12);
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, sample, widx, phase};
      do @(posedge clock); while (!req_tready);
      // bookkeeping at the accepting edge
      if (mode == MODE_WRITE) begin
         sample_mem[widx] = sample;
         write_count++;
      end else if (mode != MODE_UNUSED) begin
         expected_values.push_back(interpolate(mode, phase));
         read_count++;
      end
   endtask

   task automatic go_idle();
      req_tvalid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_length(input int unsigned len);
      csr_write_enable <= 1'b1;
      csr_write_data   <= LEN_W'(len);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_reg = len;
      @(posedge clock);
   endtask

   // phase whose needed entries are all written for length len
   function automatic logic [PHASE_W-1:0] pick_phase(input int unsigned len);
      int unsigned span, ip;
      span = (len > DEPTH) ? DEPTH : len;
      if (span <= FILL) ip = $urandom_range(0, span + 1);
      else if (span == DEPTH && $urandom_range(0, 3) == 0)
         ip = $urandom_range(DEPTH - 3, DEPTH - 1);
      else ip = $urandom_range(0, FILL - 3);
      return {ip[9:0], 16'($urandom)};
   endfunction

   // result side: random stall bursts, checking on acceptance
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0)
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            else if (expected_values[0] !== rsp_tdata)
               report_mismatch($sformatf("value %h expected %h", rsp_tdata,
                                         expected_values[0]));
            if (expected_values.size() != 0) void'(expected_values.pop_front());
         end
         // stall bursts of random length while stall_enable is set
         if (stall_enable && stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stall_enable && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   initial begin
      #3000000;
      $display("table_interpolation_reader_unit_tb NOT OK");
      $finish;
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type r;
      int unsigned lengths [5];
      int unsigned len;
      int i, k;
      logic [WIDX_W-1:0] wi;
      lengths = '{1024, 2, 1500, 4, 700};
      for (i = 0; i < DEPTH; i++) sample_mem[i] = '0;
      length_reg = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: both reads give zero, unused mode gives nothing
      rows.push_back('{MODE_LINEAR,  26'h3FFFFFF, 10'd0, 24'd0, 1'b1, 24'd0});
      rows.push_back('{MODE_HERMITE, 26'h0000000, 10'd0, 24'd0, 1'b1, 24'd0});
      rows.push_back('{MODE_UNUSED,  26'h1234567, 10'd5, 24'hABCDEF, 1'b0, 24'd0});
      foreach (rows[j]) begin
         r = rows[j];
         send_word(r.mode, r.phase, r.widx, r.sample, 1'b0);
         if (r.has_fixed && r.mode != MODE_WRITE && r.mode != MODE_UNUSED)
            expected_values[$] = r.fixed_value;
      end
      go_idle();

      // single entry: any phase returns entry zero
      set_length(1);
      rows.delete();
      rows.push_back('{MODE_WRITE,   26'h0, 10'd0, 24'h800000, 1'b0, 24'd0});
      rows.push_back('{MODE_LINEAR,  26'h3FFFFFF, 10'd0, 24'd0, 1'b1, 24'h800000});
      rows.push_back('{MODE_HERMITE, 26'h0012345, 10'd0, 24'd0, 1'b1, 24'h800000});
      rows.push_back('{MODE_WRITE,   26'h0, 10'd0, 24'h7FFFFF, 1'b0, 24'd0});
      rows.push_back('{MODE_HERMITE, 26'h3FFFFFF, 10'd0, 24'd0, 1'b1, 24'h7FFFFF});
      foreach (rows[j]) begin
         r = rows[j];
         send_word(r.mode, r.phase, r.widx, r.sample, 1'b0);
         if (r.has_fixed) expected_values[$] = r.fixed_value;
      end

      // fill the low region and the last four entries with extremes and random content
      for (i = 0; i < FILL + 4; i++) begin
         wi = (i < FILL) ? WIDX_W'(i) : WIDX_W'(DEPTH - FILL - 4 + i);
         send_word(MODE_WRITE, PHASE_W'($urandom), wi,
                   (i % 4 == 0) ? 24'h7FFFFF : (i % 4 == 1) ? 24'h800000
                                             : SAMPLE_W'($urandom), 1'b1);
      end
      go_idle();

      // directed reads at the table edges, full length
      set_length(DEPTH);
      rows.delete();
      rows.push_back('{MODE_LINEAR,  26'h0000000, 10'd0, 24'd0, 1'b0, 24'd0});
      rows.push_back('{MODE_LINEAR,  26'h000FFFF, 10'd0, 24'd0, 1'b0, 24'd0});
      rows.push_back('{MODE_LINEAR,  {10'd1022, 16'hFFFF}, 10'd0, 24'd0, 1'b0, 24'd0});
      rows.push_back('{MODE_LINEAR,  26'h3FFFFFF, 10'd0, 24'd0, 1'b1, 24'd0});
      rows.push_back('{MODE_HERMITE, 26'h0000000, 10'd0, 24'd0, 1'b0, 24'd0});
      rows.push_back('{MODE_HERMITE, 26'h000FFFF, 10'd0, 24'd0, 1'b0, 24'd0});
      rows.push_back('{MODE_HERMITE, 26'h3FFFFFF, 10'd0, 24'd0, 1'b0, 24'd0});
      rows.push_back('{MODE_HERMITE, {10'd1022, 16'h8000}, 10'd0, 24'd0, 1'b0, 24'd0});
      foreach (rows[j]) begin
         r = rows[j];
         send_word(r.mode, r.phase, r.widx, r.sample, 1'b0);
         if (r.has_fixed) expected_values[$] = r.fixed_value;
      end
      go_idle();

      // random phases over several lengths
      for (k = 0; k < 5; k++) begin
         len = lengths[k];
         set_length(len);
         for (i = 0; i < 45; i++) begin
            if (k == 4 && i >= 25) stall_enable = 1'b0;
            case ($urandom_range(0, 9))
               0: begin
                  wi = WIDX_W'($urandom);
                  send_word(MODE_WRITE, PHASE_W'($urandom), wi, SAMPLE_W'($urandom),
                            k != 4 || i < 25);
               end
               1: send_word(MODE_UNUSED, PHASE_W'($urandom), WIDX_W'($urandom),
                            SAMPLE_W'($urandom), k != 4 || i < 25);
               2, 3, 4, 5: send_word(MODE_LINEAR, pick_phase(len), '0, '0,
                                     k != 4 || i < 25);
               default: send_word(MODE_HERMITE, pick_phase(len), '0, '0,
                                  k != 4 || i < 25);
            endcase
            // pause once until everything has drained
            if (k == 1 && i == 20) begin
               req_tvalid <= 1'b0;
               while (expected_values.size() != 0) @(posedge clock);
            end
         end
         go_idle();
      end

      $display("covered %0d table writes and %0d reads over lengths 0 to 1500",
               write_count, read_count);
      if (error_count == 0 && expected_values.size() == 0)
         $display("table_interpolation_reader_unit_tb OK");
      else
         $display("table_interpolation_reader_unit_tb NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/tir_pkg.sv
design/table_interpolation_reader_unit.sv
design/tir_port_check.sv
tb/table_interpolation_reader_unit_tb.sv
